/* hw/rtl/tsla_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and cell rule functions for the two-species life automaton.
package tsla_pkg;

	localparam int GRID_SIZE = 32;
	localparam int COORD_W   = $clog2(GRID_SIZE);
	localparam int CELL_W    = 2;
	localparam int ROW_BITS  = CELL_W * GRID_SIZE;
	localparam int CFG_W     = 6;
	localparam int CNT_W     = 4;

	typedef logic [CELL_W-1:0]   cell_t;
	typedef logic [ROW_BITS-1:0] row_t;
	typedef logic [COORD_W-1:0]  coord_t;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_GEN   = 2'd2;

	localparam cell_t CELL_EMPTY = 2'd0;
	localparam cell_t CELL_O     = 2'd1;
	localparam cell_t CELL_X     = 2'd2;

	localparam logic REG_ROW_BEGIN = 1'b0;
	localparam logic REG_ROW_END   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_LOAD_UP,
		ST_LOAD_MID,
		ST_LOAD_DN,
		ST_CALC,
		ST_FINISH
	} state_t;

	function automatic cell_t cell_of(row_t r, coord_t idx);
		return r[CELL_W*idx +: CELL_W];
	endfunction

	// Neighbours arrive packed two bits each; any non-empty, non-O code counts as X.
	function automatic cell_t next_cell(cell_t old, logic [8*CELL_W-1:0] nb);
		logic [CNT_W-1:0] n_o;
		logic [CNT_W-1:0] n_x;
		logic [CNT_W-1:0] live;
		cell_t            v;
		cell_t            res;
		n_o = '0;
		n_x = '0;
		for (int i = 0; i < 8; i++) begin
			v = nb[CELL_W*i +: CELL_W];
			if (v == CELL_O) begin
				n_o = n_o + 1'b1;
			end else if (v != CELL_EMPTY) begin
				n_x = n_x + 1'b1;
			end
		end
		live = n_o + n_x;
		res = CELL_EMPTY;
		if (old != CELL_EMPTY) begin
			if (live == CNT_W'(2) || live == CNT_W'(3)) begin
				res = old;
			end
		end else if (live == CNT_W'(3)) begin
			res = (n_o >= n_x) ? CELL_O : CELL_X;
		end
		return res;
	endfunction

endpackage

/* hw/rtl/two_species_life_automaton.sv */
`timescale 1ns / 1ps
// Two-species life automaton: a 32 by 32 toroidal world of empty, O and X cells.
// The input channel (in_valid, in_stall) carries one request word: write a cell,
// read a cell or compute one generation. Every request gives exactly one result
// word on the output channel (out_valid, out_stall): the cell read, or for a
// generation whether any computed cell changed. Rows begin to end minus one are
// computed (registers row_begin and row_end); all other rows become empty.
// The world sits in two row-wide buffers of 32 rows; each row has a valid flag,
// and a row without its flag reads as empty, so reset takes effect at once and
// needs no clearing pass. Reset also makes buffer a current and sets the range
// to the whole grid.
// A write or read reads the row at the accepting edge; the row is then modified
// and written back as the result is loaded.
// A generation computes one cell a cycle from three row registers (up, mid,
// dn) and, between rows, loads the next row from memory in state ST_LOAD_DN.
// A generation over an empty range and an unused request code go straight to
// the finish state, which loads the result.
// One request is in work at a time; in_stall is low only when idle, and a new
// word is taken the cycle after a result is loaded into the output register.
// A stalled result holds back the next result until the receiver takes it.
module two_species_life_automaton
	import tsla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [4:0]           col,
	input  logic [4:0]           row,
	input  logic [1:0]           cell_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           cell_out,
	output logic                 world_changed,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]     row_begin_q, row_end_q, end_eff;
	logic                 cur_is_b_q;
	logic [GRID_SIZE-1:0] vld_a_q, vld_b_q;
	logic                 out_valid_q;
	cell_t                cell_out_q;
	logic                 world_changed_q;

	// Request held for the duration of its work.
	logic [1:0]           op_q;
	coord_t               row_q, col_q;
	cell_t                cell_q;

	// Generation walk.
	coord_t               r_q, c_q;
	row_t                 up_q, mid_q, dn_q, nrow_q;
	logic                 chg_q;

	// Memories and their registered read data.
	row_t                 grid_a [GRID_SIZE];
	row_t                 grid_b [GRID_SIZE];
	row_t                 rd_a_q, rd_b_q;
	logic                 rd_ok_q;

	logic                 in_acc, out_free, res_load;
	logic                 range_empty, last_col, last_row;
	logic                 mem_re, mem_we, mem_to_b;
	coord_t               mem_raddr, mem_waddr;
	row_t                 mem_wdata;
	row_t                 row_in, row_upd, row_merged;
	coord_t               cl, cr;
	cell_t                old_cell, new_cell;
	cell_t                wr_cell;

	assign end_eff     = (row_end_q > CFG_W'(GRID_SIZE)) ? CFG_W'(GRID_SIZE) : row_end_q;
	assign range_empty = (row_begin_q >= end_eff);
	assign last_col    = (c_q == COORD_W'(GRID_SIZE - 1));
	assign last_row    = ((CFG_W'(r_q) + CFG_W'(1)) == end_eff);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign row_in = rd_ok_q ? (cur_is_b_q ? rd_b_q : rd_a_q) : '0;

	// A written code three behaves as X, so it is stored as X.
	assign wr_cell = (cell_in == 2'd3) ? CELL_X : cell_in;

	// Cell update for the generation walk.
	assign cl       = c_q - 1'b1;
	assign cr       = c_q + 1'b1;
	assign old_cell = cell_of(mid_q, c_q);
	assign new_cell = next_cell(old_cell, {cell_of(up_q, cl), cell_of(up_q, c_q),
		cell_of(up_q, cr), cell_of(mid_q, cl), cell_of(mid_q, cr),
		cell_of(dn_q, cl), cell_of(dn_q, c_q), cell_of(dn_q, cr)});

	always_comb begin
		row_merged = nrow_q;
		row_merged[CELL_W*c_q +: CELL_W] = new_cell;
		row_upd = row_in;
		row_upd[CELL_W*col_q +: CELL_W] = cell_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (req_type)
						REQ_WRITE, REQ_READ: state_d = ST_CELL;
						REQ_GEN:             state_d = range_empty ? ST_FINISH : ST_LOAD_UP;
						default:             state_d = ST_FINISH;
					endcase
				end
			end
			ST_CELL: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_LOAD_UP:  state_d = ST_LOAD_MID;
			ST_LOAD_MID: state_d = ST_LOAD_DN;
			ST_LOAD_DN:  state_d = ST_CALC;
			ST_CALC: begin
				if (last_col) state_d = last_row ? ST_FINISH : ST_LOAD_DN;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory control and handshake outputs.
	always_comb begin
		in_stall  = 1'b1;
		mem_re    = 1'b0;
		mem_raddr = r_q;
		mem_we    = 1'b0;
		mem_waddr = r_q;
		mem_wdata = row_merged;
		mem_to_b  = !cur_is_b_q;
		res_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_re    = in_acc;
				mem_raddr = (req_type == REQ_GEN) ?
					COORD_W'(row_begin_q[COORD_W-1:0] - 1'b1) : row;
			end
			ST_CELL: begin
				res_load  = out_free;
				mem_we    = out_free && (op_q == REQ_WRITE);
				mem_waddr = row_q;
				mem_wdata = row_upd;
				mem_to_b  = cur_is_b_q;
			end
			ST_LOAD_UP: begin
				mem_re    = 1'b1;
				mem_raddr = r_q;
			end
			ST_LOAD_MID: begin
				mem_re    = 1'b1;
				mem_raddr = r_q + 1'b1;
			end
			ST_LOAD_DN: begin
			end
			ST_CALC: begin
				mem_we    = last_col;
				mem_re    = last_col && !last_row;
				mem_raddr = r_q + COORD_W'(2);
			end
			ST_FINISH: begin
				res_load  = out_free;
			end
			default: begin
			end
		endcase
	end

	// Row buffers; data is registered on every read.
	always_ff @(posedge clk) begin
		if (mem_we && !mem_to_b) grid_a[mem_waddr] <= mem_wdata;
		if (mem_re) rd_a_q <= grid_a[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_to_b) grid_b[mem_waddr] <= mem_wdata;
		if (mem_re) rd_b_q <= grid_b[mem_raddr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_begin_q <= '0;
			row_end_q   <= CFG_W'(GRID_SIZE);
			cur_is_b_q  <= 1'b0;
			vld_a_q     <= '0;
			vld_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW_BEGIN: row_begin_q <= cfg_data;
					REG_ROW_END:   row_end_q   <= cfg_data;
					default:       row_begin_q <= cfg_data;
				endcase
			end
			// A new generation starts from an empty target buffer.
			if (in_acc && req_type == REQ_GEN) begin
				if (cur_is_b_q) vld_a_q <= '0;
				else            vld_b_q <= '0;
			end
			if (mem_we) begin
				if (mem_to_b) vld_b_q[mem_waddr] <= 1'b1;
				else          vld_a_q[mem_waddr] <= 1'b1;
			end
			if (state_q == ST_FINISH && res_load && op_q == REQ_GEN) begin
				cur_is_b_q <= !cur_is_b_q;
			end
			if (res_load)                     out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_ok_q <= cur_is_b_q ? vld_b_q[mem_raddr] : vld_a_q[mem_raddr];
		end
		if (in_acc) begin
			op_q   <= req_type;
			row_q  <= row;
			col_q  <= col;
			cell_q <= wr_cell;
			r_q    <= row_begin_q[COORD_W-1:0];
			chg_q  <= 1'b0;
		end
		unique case (state_q)
			ST_LOAD_UP:  up_q  <= row_in;
			ST_LOAD_MID: mid_q <= row_in;
			ST_LOAD_DN: begin
				dn_q <= row_in;
				c_q  <= '0;
			end
			ST_CALC: begin
				nrow_q <= row_merged;
				c_q    <= c_q + 1'b1;
				if (new_cell != old_cell) chg_q <= 1'b1;
				if (last_col) begin
					up_q  <= mid_q;
					mid_q <= dn_q;
					r_q   <= r_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (res_load) begin
			cell_out_q      <= (state_q == ST_CELL && op_q == REQ_READ) ?
				cell_of(row_in, col_q) : CELL_EMPTY;
			world_changed_q <= (state_q == ST_FINISH && op_q == REQ_GEN) ? chg_q : 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_out      = cell_out_q;
	assign world_changed = world_changed_q;

endmodule

/* hw/rtl/tsla_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the two-species life automaton, bound to the top level.
module tsla_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] cell_out,
	input logic       world_changed
);

	// A stalled result word must stay put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_out) && $stable(world_changed))
		else $error("result word changed while stalled");

	// Only one request is in work, so the input closes right after a word is taken.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request is in work");

	// A read result never carries a change flag.
	a_fields_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_out != 2'd0 |-> !world_changed)
		else $error("cell and change flag both set");

	// Code three is never stored, so it can never be read back.
	a_cell_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_out != 2'd3)
		else $error("illegal cell code on output");

endmodule

bind two_species_life_automaton tsla_checker u_tsla_checker (.*);
